/* rtl/oahs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahs_pkg
// shared types and constants of the open addressing hash set
// ----------------------------------------------------------------------------
package oahs_pkg;

    localparam int SLOTS_DEF    = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam logic [31:0] HASH_MULT = 32'd16777619;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_TOMB  = 2'd1;
    localparam logic [1:0] MARK_LIVE  = 2'd2;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;

    localparam logic [2:0] RES_INSERTED = 3'd0;
    localparam logic [2:0] RES_PRESENT  = 3'd1;
    localparam logic [2:0] RES_REMOVED  = 3'd2;
    localparam logic [2:0] RES_FOUND    = 3'd3;
    localparam logic [2:0] RES_ABSENT   = 3'd4;
    localparam logic [2:0] RES_FULL     = 3'd5;

    localparam logic [1:0] CFG_BASIS  = 2'd0;
    localparam logic [1:0] CFG_LINEAR = 2'd1;
    localparam logic [1:0] CFG_SQUARE = 2'd2;
    localparam logic [1:0] CFG_MAXUSE = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

/* rtl/oahs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahs_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module oahs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/open_addressing_hash_set_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_set_core
// hash set of keys in a slot table with quadratic probing
// ----------------------------------------------------------------------------
// a word on s_ carries mode and key; one word on m_ returns result code, slot
// and live count. items are handled one at a time: the fnv hash takes one
// multiply per key byte, then each probed slot takes a read of the mark and
// key memories, then the compare, and an update adds a write of the slot
// before the result is offered. the result sits in an output register until
// taken; s_ready stays low while it waits.
// after reset a clearing pass writes every mark to empty, one slot a cycle,
// before the first word is taken; config writes work anytime.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_core #(
    parameter int SLOTS    = oahs_pkg::SLOTS_DEF,
    parameter int KEY_BITS = oahs_pkg::KEY_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_mode,
    input  logic [31:0]   s_key,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_result_code,
    output logic [7:0]    m_slot,
    output logic [8:0]    m_live_count
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam int NB = (KEY_BITS + 7) / 8;
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

    logic [31:0] basis_reg;
    logic [7:0]  lin_reg, sq_reg;
    logic [8:0]  maxu_reg;

    oahs_pkg::state_t state_reg, state_next;

    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] n_reg, n_next;        // probe step number i
    logic [AW-1:0] isq_reg, isq_next;    // (i+1)*(i+1) mod SLOTS
    logic [AW-1:0] tomb_reg, tomb_next;
    logic          tomb_ok_reg, tomb_ok_next;
    logic [BW-1:0] byte_reg, byte_next;
    logic [31:0]   h_reg, h_next;
    logic [1:0]    mode_reg, mode_next;
    logic [KW-1:0] key_reg, key_next;
    logic [8:0]    live_reg, live_next, used_reg, used_next;
    logic [2:0]    code_reg, code_next;
    logic [7:0]    slot_reg, slot_next;
    logic          wr_reg, wr_next;
    logic [1:0]    wmark_reg, wmark_next;
    logic [AW-1:0] waddr_reg, waddr_next;

    logic          mem_we, key_we;
    logic [AW-1:0] mem_addr;
    logic [1:0]    mark_wdata, mark_rdata;
    logic [KW-1:0] key_rdata;

    oahs_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(mark_wdata),
        .rdata(mark_rdata)
    );
    oahs_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key (
        .aclk(aclk), .we(key_we), .addr(mem_addr), .wdata(key_reg),
        .rdata(key_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg <= 32'd2166136261;
            lin_reg   <= 8'd0;
            sq_reg    <= 8'd1;
            maxu_reg  <= 9'd192;
        end else if (cfg_we) begin
            case (cfg_index)
                oahs_pkg::CFG_BASIS:  basis_reg <= cfg_data;
                oahs_pkg::CFG_LINEAR: lin_reg   <= cfg_data[7:0];
                oahs_pkg::CFG_SQUARE: sq_reg    <= cfg_data[7:0];
                oahs_pkg::CFG_MAXUSE: maxu_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oahs_pkg::ST_CLEAR;
            live_reg  <= '0;
            used_reg  <= '0;
            wr_reg    <= 1'b0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            used_reg  <= used_next;
            wr_reg    <= wr_next;
            pos_reg   <= pos_next;
        end
        n_reg       <= n_next;
        isq_reg     <= isq_next;
        tomb_reg    <= tomb_next;
        tomb_ok_reg <= tomb_ok_next;
        byte_reg    <= byte_next;
        h_reg       <= h_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        code_reg    <= code_next;
        slot_reg    <= slot_next;
        wmark_reg   <= wmark_next;
        waddr_reg   <= waddr_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            oahs_pkg::ST_CLEAR:
                if (pos_reg == AW'(SLOTS - 1)) state_next = oahs_pkg::ST_IDLE;
            oahs_pkg::ST_IDLE:
                if (s_valid) state_next = oahs_pkg::ST_HASH;
            oahs_pkg::ST_HASH:
                if (byte_reg == BW'(NB - 1)) state_next = oahs_pkg::ST_READ;
            oahs_pkg::ST_READ:  state_next = oahs_pkg::ST_CHECK;
            oahs_pkg::ST_CHECK: begin
                if (mark_rdata == oahs_pkg::MARK_EMPTY ||
                    (mark_rdata == oahs_pkg::MARK_LIVE && key_rdata == key_reg) ||
                    n_reg == CW'(SLOTS - 1)) begin
                    state_next = oahs_pkg::ST_DONE;
                end else begin
                    state_next = oahs_pkg::ST_READ;
                end
            end
            oahs_pkg::ST_DONE:
                if (m_ready && !wr_reg) state_next = oahs_pkg::ST_IDLE;
            default: state_next = oahs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    logic [7:0]    hbyte;
    logic [AW-1:0] step;
    logic [CW-1:0] i1;
    logic          found, stop;
    always_comb begin
        hbyte = 8'(key_reg >> (8 * byte_reg));
        i1    = n_reg + CW'(1);
        step  = AW'(lin_reg * i1) + AW'(sq_reg * isq_reg);
        found = (mark_rdata == oahs_pkg::MARK_LIVE) && (key_rdata == key_reg);
        stop  = (mark_rdata == oahs_pkg::MARK_EMPTY) || found ||
                (n_reg == CW'(SLOTS - 1));

        pos_next = pos_reg; n_next = n_reg; isq_next = isq_reg;
        tomb_next = tomb_reg; tomb_ok_next = tomb_ok_reg;
        byte_next = byte_reg; h_next = h_reg; mode_next = mode_reg;
        key_next = key_reg; live_next = live_reg; used_next = used_reg;
        code_next = code_reg; slot_next = slot_reg; wr_next = 1'b0;
        wmark_next = wmark_reg; waddr_next = waddr_reg;
        s_ready = 1'b0;
        mem_we = 1'b0; key_we = 1'b0; mem_addr = pos_reg;
        mark_wdata = oahs_pkg::MARK_EMPTY;

        case (state_reg)
            oahs_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                pos_next = pos_reg + AW'(1);
            end
            oahs_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                mode_next  = s_mode;
                key_next   = KW'(s_key);
                h_next     = basis_reg;
                byte_next  = '0;
            end
            oahs_pkg::ST_HASH: begin
                h_next    = (h_reg ^ {24'd0, hbyte}) * oahs_pkg::HASH_MULT;
                byte_next = byte_reg + BW'(1);
                n_next = '0; isq_next = AW'(1); tomb_ok_next = 1'b0;
                // home slot from the finished hash
                if (byte_reg == BW'(NB - 1)) begin
                    pos_next = AW'(h_next);
                end
            end
            oahs_pkg::ST_READ: ;
            oahs_pkg::ST_CHECK: begin
                if (mark_rdata == oahs_pkg::MARK_TOMB && !tomb_ok_reg) begin
                    tomb_next = pos_reg; tomb_ok_next = 1'b1;
                end
                if (!stop) begin
                    pos_next = pos_reg + step;
                    n_next   = i1;
                    isq_next = isq_reg + AW'(2 * i1) + AW'(1);
                end else begin
                    code_next = oahs_pkg::RES_ABSENT;
                    slot_next = '0;
                    if (mode_reg == oahs_pkg::MODE_INSERT) begin
                        if (found) begin
                            code_next = oahs_pkg::RES_PRESENT;
                            slot_next = 8'(pos_reg);
                        end else if (mark_rdata == oahs_pkg::MARK_TOMB && !tomb_ok_reg) begin
                            code_next = oahs_pkg::RES_INSERTED; slot_next = 8'(pos_reg);
                            wr_next = 1'b1; waddr_next = pos_reg;
                            wmark_next = oahs_pkg::MARK_LIVE; live_next = live_reg + 9'd1;
                        end else if (tomb_ok_reg) begin
                            code_next = oahs_pkg::RES_INSERTED; slot_next = 8'(tomb_reg);
                            wr_next = 1'b1; waddr_next = tomb_reg;
                            wmark_next = oahs_pkg::MARK_LIVE; live_next = live_reg + 9'd1;
                        end else if (mark_rdata == oahs_pkg::MARK_EMPTY &&
                                     used_reg < maxu_reg) begin
                            code_next = oahs_pkg::RES_INSERTED; slot_next = 8'(pos_reg);
                            wr_next = 1'b1; waddr_next = pos_reg;
                            wmark_next = oahs_pkg::MARK_LIVE; live_next = live_reg + 9'd1;
                            used_next = used_reg + 9'd1;
                        end else begin
                            code_next = oahs_pkg::RES_FULL;
                        end
                    end else if (found) begin
                        slot_next = 8'(pos_reg);
                        if (mode_reg == oahs_pkg::MODE_REMOVE) begin
                            code_next = oahs_pkg::RES_REMOVED;
                            wr_next = 1'b1; waddr_next = pos_reg;
                            wmark_next = oahs_pkg::MARK_TOMB;
                            if (live_reg != '0) live_next = live_reg - 9'd1;
                        end else begin
                            code_next = oahs_pkg::RES_FOUND;
                        end
                    end
                end
            end
            oahs_pkg::ST_DONE: begin
                if (wr_reg) begin
                    mem_addr   = waddr_reg;
                    mem_we     = 1'b1;
                    key_we     = (wmark_reg == oahs_pkg::MARK_LIVE);
                    mark_wdata = wmark_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = (state_reg == oahs_pkg::ST_DONE) && !wr_reg;
    assign m_result_code = code_reg;
    assign m_slot        = slot_reg;
    assign m_live_count  = live_reg;
endmodule
